// ===== hw/rtl/ltok_pkg.sv =====
`default_nettype none

package ltok_pkg;

	// Field widths fixed by the item formats.
	localparam int CHAR_W  = 8;
	localparam int LEVEL_W = 6;
	localparam int ERR_W   = 2;
	localparam int LVL_W   = 8;   // leading space count and its quotient
	localparam int NCHAR   = 5;   // most token bytes one request can release
	localparam int NCHAR_W = 3;

	// Defaults for the top-level parameters.
	localparam int INDENT_WIDTH_DEF     = 4;
	localparam int MAX_INDENT_LEVEL_DEF = 63;
	localparam int QUEUE_DEPTH_DEF      = 4;

	// Line outcome error codes.
	localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
	localparam logic [ERR_W-1:0] ERR_INDENT  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_BRACKET = 2'd2;
	localparam logic [ERR_W-1:0] ERR_QUOTE   = 2'd3;

	// Character codes.
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [CHAR_W-1:0] CH_HASH    = 8'h23;
	localparam logic [CHAR_W-1:0] CH_SEMI    = 8'h3B;
	localparam logic [CHAR_W-1:0] CH_BAR     = 8'h7C;
	localparam logic [CHAR_W-1:0] CH_DQUOTE  = 8'h22;
	localparam logic [CHAR_W-1:0] CH_SQUOTE  = 8'h27;
	localparam logic [CHAR_W-1:0] CH_BSLASH  = 8'h5C;
	localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_LPAREN  = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RPAREN  = 8'h29;
	localparam logic [CHAR_W-1:0] CH_LBRACE  = 8'h7B;
	localparam logic [CHAR_W-1:0] CH_RBRACE  = 8'h7D;
	localparam logic [CHAR_W-1:0] CH_LBRACK  = 8'h5B;
	localparam logic [CHAR_W-1:0] CH_RBRACK  = 8'h5D;

	// All results caused by one input item: token bytes first, then
	// an optional line outcome.
	typedef struct packed {
		logic [NCHAR_W-1:0]           nchar;
		logic [NCHAR-1:0][CHAR_W-1:0] chars;
		logic [NCHAR-1:0]             ends;
		logic                         outcome;
		logic [LEVEL_W-1:0]           level;
		logic [ERR_W-1:0]             err;
	} cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/line_tokenizer_with_indent.sv =====
// The results of an accepted item are queued as one request, behind any earlier requests.
// Throughput: one input item per cycle while the result queue has room; the output
// side sends one result per cycle while m_axis_tready is high, in order within each item.
// The queue depth (QUEUE_DEPTH requests) sets how long bursts of results can be absorbed.
// Reset (arst_n low, asynchronous) returns the scanner to start of line and empties the queue.
`default_nettype none

module line_tokenizer_with_indent import ltok_pkg::*; #(
	parameter int INDENT_WIDTH     = INDENT_WIDTH_DEF,
	parameter int MAX_INDENT_LEVEL = MAX_INDENT_LEVEL_DEF,
	parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // in_char
	input  wire logic        s_axis_tuser,  // kind
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // out_char, token_end, indent_level, error_code
	output logic             m_axis_tuser,  // result_kind
	output logic             m_axis_tlast   // last_of_run
);

	logic push;
	logic pop;
	logic q_full;
	logic q_empty;
	cmd_t push_cmd;
	cmd_t head;

	// Scanner: accepts bytes and line ends, builds at most one request per item.
	ltok_front #(
		.INDENT_WIDTH     (INDENT_WIDTH),
		.MAX_INDENT_LEVEL (MAX_INDENT_LEVEL)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (s_axis_tvalid),
		.item_kind  (s_axis_tuser),
		.item_char  (s_axis_tdata),
		.item_ready (s_axis_tready),
		.q_full     (q_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	// Request queue between scanner and emitter.
	ltok_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	// Emitter: sends the results of each request in order.
	ltok_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_empty       (q_empty),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/ltok_front.sv =====
`default_nettype none

module ltok_front import ltok_pkg::*; #(
	parameter int INDENT_WIDTH     = INDENT_WIDTH_DEF,
	parameter int MAX_INDENT_LEVEL = MAX_INDENT_LEVEL_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	input  wire logic              item_kind,
	input  wire logic [CHAR_W-1:0] item_char,
	output logic                   item_ready,
	input  wire logic              q_full,
	output logic                   push,
	output cmd_t                   push_cmd
);

	localparam int REM_W = (INDENT_WIDTH > 1) ? $clog2(INDENT_WIDTH) : 1;

	// Scan mode codes.
	localparam logic [2:0] M_LEAD    = 3'd0;
	localparam logic [2:0] M_NORM    = 3'd1;
	localparam logic [2:0] M_QUOTE   = 3'd2;
	localparam logic [2:0] M_COMMENT = 3'd3;
	localparam logic [2:0] M_SKIP    = 3'd4;

	// Token length code for a long token with one byte still held.
	localparam logic [2:0] TL_LONG = 3'd5;

	typedef struct packed {
		logic [2:0]              mode;
		logic [2:0]              tl;
		logic [3:0][CHAR_W-1:0]  hb;
		logic                    ats;
		logic                    esc;
		logic [ERR_W-1:0]        le;
		cmd_t                    c;
	} work_t;

	// Append one token byte to the result list.
	function automatic work_t f_put(work_t w, logic [CHAR_W-1:0] ch, logic e);
		w.c.chars[w.c.nchar] = ch;
		w.c.ends[w.c.nchar]  = e;
		w.c.nchar            = w.c.nchar + 3'd1;
		return w;
	endfunction

	// Add a byte to the current token; the last byte always stays held.
	function automatic work_t f_add(work_t w, logic [CHAR_W-1:0] ch);
		if (w.tl < 3'd4) begin
			w.hb[w.tl[1:0]] = ch;
			w.tl = w.tl + 3'd1;
		end else if (w.tl == 3'd4) begin
			for (int i = 0; i < 4; i++)
				w = f_put(w, w.hb[i], 1'b0);
			w.hb[0] = ch;
			w.tl = TL_LONG;
		end else begin
			w = f_put(w, w.hb[0], 1'b0);
			w.hb[0] = ch;
		end
		return w;
	endfunction

	// Release the held bytes of a token, rewriting short quoted forms.
	function automatic work_t f_flush(work_t w);
		if (w.tl != 3'd0) begin
			if (w.tl == 3'd3 && w.hb[0] == CH_DQUOTE && w.hb[2] == CH_DQUOTE) begin
				w.hb[0] = CH_SQUOTE;
				w.hb[2] = CH_SQUOTE;
			end else if (w.tl == 3'd4 && w.hb[0] == CH_DQUOTE &&
			             w.hb[1] == CH_BSLASH && w.hb[3] == CH_DQUOTE) begin
				w.hb[0] = CH_SQUOTE;
				w.hb[3] = CH_SQUOTE;
			end
			if (w.tl == TL_LONG) begin
				w = f_put(w, w.hb[0], 1'b1);
			end else begin
				for (int i = 0; i < 4; i++)
					if (3'(i) < w.tl)
						w = f_put(w, w.hb[i], 3'(i + 1) == w.tl);
			end
			w.tl  = 3'd0;
			w.ats = 1'b1;
		end
		return w;
	endfunction

	// One byte outside quotes after the indentation.
	function automatic work_t f_normal(work_t w, logic [CHAR_W-1:0] ch);
		if (!(ch == CH_CR || ch == CH_LF)) begin
			if (ch == CH_HASH) begin
				w = f_flush(w);
				w.mode = M_COMMENT;
			end else if (ch == CH_DQUOTE) begin
				w = f_add(w, ch);
				w.esc  = 1'b0;
				w.mode = M_QUOTE;
			end else if (ch == CH_SPACE) begin
				w = f_flush(w);
			end else if (ch == CH_SEMI) begin
				w = f_flush(w);
				w = f_put(w, CH_SEMI, 1'b1);
				w.ats = 1'b1;
			end else if (ch == CH_BAR) begin
				if (!w.ats && w.tl == 3'd0) begin
					w = f_put(w, CH_BAR, 1'b1);
					w.ats = 1'b1;
				end else begin
					w = f_add(w, ch);
				end
			end else if (ch == CH_LPAREN || ch == CH_RPAREN || ch == CH_LBRACE ||
			             ch == CH_RBRACE || ch == CH_LBRACK || ch == CH_RBRACK) begin
				w.tl   = 3'd0;
				w.le   = ERR_BRACKET;
				w.mode = M_SKIP;
			end else begin
				w = f_add(w, ch);
			end
		end
		return w;
	endfunction

	logic [2:0]             mode_q;
	logic [2:0]             tl_q;
	logic [3:0][CHAR_W-1:0] hb_q;
	logic                   ats_q;
	logic                   esc_q;
	logic [ERR_W-1:0]       le_q;
	logic [LVL_W-1:0]       sc_q;
	logic [REM_W-1:0]       rem_q;
	logic [LVL_W-1:0]       lvl_q;

	work_t            w;
	logic [LVL_W-1:0] sc_d;
	logic [REM_W-1:0] rem_d;
	logic [LVL_W-1:0] lvl_d;
	logic             bad;
	logic             accept;

	assign item_ready = !q_full;
	assign accept     = item_valid && item_ready;

	// Indentation is checked against the space count and a running quotient and remainder.
	assign bad = (sc_q == {LVL_W{1'b1}}) || (rem_q != '0) ||
	             (lvl_q > LVL_W'(MAX_INDENT_LEVEL));

	// Classify one item and collect the results it causes.
	always_comb begin
		w.mode = mode_q;
		w.tl   = tl_q;
		w.hb   = hb_q;
		w.ats  = ats_q;
		w.esc  = esc_q;
		w.le   = le_q;
		w.c    = '0;
		sc_d   = sc_q;
		rem_d  = rem_q;
		lvl_d  = lvl_q;
		if (!item_kind) begin
			unique case (mode_q)
				M_LEAD: begin
					if (item_char == CH_SPACE) begin
						if (sc_q != {LVL_W{1'b1}}) begin
							sc_d = sc_q + 1'b1;
							if (rem_q == REM_W'(INDENT_WIDTH - 1)) begin
								rem_d = '0;
								lvl_d = lvl_q + 1'b1;
							end else begin
								rem_d = rem_q + 1'b1;
							end
						end
					end else if (bad) begin
						w.le   = ERR_INDENT;
						w.mode = M_SKIP;
					end else begin
						w.mode = M_NORM;
						w = f_normal(w, item_char);
					end
				end
				M_NORM: begin
					w = f_normal(w, item_char);
				end
				M_QUOTE: begin
					if (item_char == CH_DQUOTE && !esc_q) begin
						w = f_add(w, item_char);
						w.mode = M_NORM;
					end else begin
						w.esc = (item_char == CH_BSLASH) ? !esc_q : 1'b0;
						w = f_add(w, item_char);
					end
				end
				default: ;
			endcase
		end else begin
			if (mode_q == M_LEAD) begin
				if (bad)
					w.le = ERR_INDENT;
			end else if (mode_q == M_QUOTE) begin
				w = f_add(w, CH_SPACE);
				w = f_flush(w);
				if (w.le == ERR_NONE)
					w.le = ERR_QUOTE;
			end else if (mode_q == M_NORM) begin
				w = f_flush(w);
			end
			w.c.outcome = 1'b1;
			w.c.err     = w.le;
			w.c.level   = (w.le == ERR_INDENT) ? '0 : lvl_q[LEVEL_W-1:0];
			// Line end: back to the start-of-line state.
			w.mode = M_LEAD;
			w.tl   = 3'd0;
			w.ats  = 1'b0;
			w.esc  = 1'b0;
			w.le   = ERR_NONE;
			sc_d   = '0;
			rem_d  = '0;
			lvl_d  = '0;
		end
	end

	assign push     = accept && (w.c.nchar != '0 || w.c.outcome);
	assign push_cmd = w.c;

	// Scanner state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_LEAD;
			tl_q   <= 3'd0;
			ats_q  <= 1'b0;
			esc_q  <= 1'b0;
			le_q   <= ERR_NONE;
			sc_q   <= '0;
			rem_q  <= '0;
			lvl_q  <= '0;
		end else if (accept) begin
			mode_q <= w.mode;
			tl_q   <= w.tl;
			ats_q  <= w.ats;
			esc_q  <= w.esc;
			le_q   <= w.le;
			sc_q   <= sc_d;
			rem_q  <= rem_d;
			lvl_q  <= lvl_d;
		end
	end

	// Held token bytes need no reset.
	always_ff @(posedge clk) begin
		if (accept)
			hb_q <= w.hb;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ltok_queue.sv =====
`default_nettype none

module ltok_queue import ltok_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output cmd_t      head,
	output logic      full,
	output logic      empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_cmd;
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("request written into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("request taken from an empty queue");

	a_fill_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue fill level did not follow a write");

endmodule

`default_nettype wire

// ===== hw/rtl/ltok_back.sv =====
`default_nettype none

module ltok_back import ltok_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        head,
	input  wire logic        q_empty,
	output logic             pop,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // out_char, token_end, indent_level, error_code
	output logic             m_axis_tuser,  // result_kind
	output logic             m_axis_tlast   // last_of_run
);

	logic [NCHAR_W-1:0] idx_q;
	logic [NCHAR_W-1:0] total;
	logic               is_char;
	logic               last;
	logic               accept;
	logic [CHAR_W-1:0]  ch;
	logic               tend;
	logic [LEVEL_W-1:0] level;
	logic [ERR_W-1:0]   err;

	// Walk the results of the head request, one per cycle while m_axis_tready is high.
	assign total   = head.nchar + NCHAR_W'(head.outcome);
	assign is_char = idx_q < head.nchar;
	assign last    = (idx_q == total - 1'b1);
	assign accept  = m_axis_tvalid && m_axis_tready;
	assign pop     = accept && last;

	assign ch    = is_char ? head.chars[idx_q] : '0;
	assign tend  = is_char ? head.ends[idx_q] : 1'b0;
	assign level = is_char ? '0 : head.level;
	assign err   = is_char ? ERR_NONE : head.err;

	assign m_axis_tvalid = !q_empty;
	assign m_axis_tuser  = !is_char;
	assign m_axis_tlast  = last;
	assign m_axis_tdata  = {7'd0, err, level, tend, ch};

	// Result index within the head request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (accept) begin
			idx_q <= last ? '0 : idx_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== sim/line_tokenizer_with_indent_test.sv =====
`default_nettype none

module line_tokenizer_with_indent_test;
	import ltok_pkg::*;

	// Length of the long output stall used to fill the result queue.
	localparam int LONG_STALL = 300;

	// Scanner position within a line, as tracked by the predictor.
	typedef enum logic [2:0] {
		SCAN_LEAD,
		SCAN_NORMAL,
		SCAN_QUOTED,
		SCAN_COMMENT,
		SCAN_SKIP
	} scan_state_t;

	// One result as seen on the output stream.
	typedef struct {
		logic               is_outcome;
		logic [CHAR_W-1:0]  ch;
		logic               tok_end;
		logic [LEVEL_W-1:0] level;
		logic [ERR_W-1:0]   err;
		logic               last;
	} tok_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	line_tokenizer_with_indent dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #10 clk = ~clk;

	// Predictor state for the current line.
	scan_state_t       scan;
	int                spaces;
	int                held_len;
	logic [CHAR_W-1:0] held [4];
	logic              token_seen;
	logic              esc;
	logic [ERR_W-1:0]  line_err;

	tok_result_t       expected_results [$];
	tok_result_t       item_results [$];
	logic [7:0]        line_buf [$];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int stall_asked = 0;
	int stall_taken = 0;
	int stall_left = 0;

	int lines_sent = 0;
	int items_sent = 0;
	int results_checked = 0;
	int outcomes_checked = 0;
	int fail_count = 0;

	// Return the predictor to start of line.
	function automatic void clear_line();
		scan = SCAN_LEAD;
		spaces = 0;
		held_len = 0;
		token_seen = 1'b0;
		esc = 1'b0;
		line_err = ERR_NONE;
	endfunction

	// Append one byte to the line being built.
	function automatic void buf_byte(logic [7:0] b);
		line_buf.insert(line_buf.size(), b);
	endfunction

	function automatic void emit_byte(logic [CHAR_W-1:0] c, logic e);
		tok_result_t r;
		r.is_outcome = 1'b0;
		r.ch = c;
		r.tok_end = e;
		r.level = '0;
		r.err = ERR_NONE;
		r.last = 1'b0;
		item_results.insert(item_results.size(), r);
	endfunction

	// Keep up to four bytes of the token back; beyond that, release them and keep only the newest.
	function automatic void hold_byte(logic [CHAR_W-1:0] c);
		if (held_len < 4) begin
			held[held_len] = c;
			held_len++;
		end else if (held_len == 4) begin
			for (int i = 0; i < 4; i++)
				emit_byte(held[i], 1'b0);
			held[0] = c;
			held_len = 5;
		end else begin
			emit_byte(held[0], 1'b0);
			held[0] = c;
		end
	endfunction

	// Close the current token, turning "x" and "\x" into single-quoted form.
	function automatic void flush_token();
		if (held_len == 0)
			return;
		if (held_len == 3 && held[0] == CH_DQUOTE && held[2] == CH_DQUOTE) begin
			held[0] = CH_SQUOTE;
			held[2] = CH_SQUOTE;
		end else if (held_len == 4 && held[0] == CH_DQUOTE && held[1] == CH_BSLASH &&
		             held[3] == CH_DQUOTE) begin
			held[0] = CH_SQUOTE;
			held[3] = CH_SQUOTE;
		end
		if (held_len == 5) begin
			emit_byte(held[0], 1'b1);
		end else begin
			for (int i = 0; i < held_len; i++)
				emit_byte(held[i], i == held_len - 1);
		end
		held_len = 0;
		token_seen = 1'b1;
	endfunction

	function automatic logic indent_is_bad();
		return spaces >= 255 || (spaces % INDENT_WIDTH_DEF) != 0 ||
		       (spaces / INDENT_WIDTH_DEF) > MAX_INDENT_LEVEL_DEF;
	endfunction

	// Handle one byte outside quotes.
	function automatic void scan_normal(logic [CHAR_W-1:0] c);
		if (c == CH_CR || c == CH_LF)
			return;
		if (c == CH_HASH) begin
			flush_token();
			scan = SCAN_COMMENT;
		end else if (c == CH_DQUOTE) begin
			hold_byte(c);
			esc = 1'b0;
			scan = SCAN_QUOTED;
		end else if (c == CH_SPACE) begin
			flush_token();
		end else if (c == CH_SEMI) begin
			flush_token();
			emit_byte(CH_SEMI, 1'b1);
			token_seen = 1'b1;
		end else if (c == CH_BAR) begin
			if (!token_seen && held_len == 0) begin
				emit_byte(CH_BAR, 1'b1);
				token_seen = 1'b1;
			end else begin
				hold_byte(c);
			end
		end else if (c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACE ||
		             c == CH_RBRACE || c == CH_LBRACK || c == CH_RBRACK) begin
			held_len = 0;
			line_err = ERR_BRACKET;
			scan = SCAN_SKIP;
		end else begin
			hold_byte(c);
		end
	endfunction

	// Work out every result of one accepted request and queue them.
	function automatic void predict_item(logic kind, logic [CHAR_W-1:0] c);
		tok_result_t r;
		item_results.delete();
		if (!kind) begin
			case (scan)
				SCAN_LEAD: begin
					if (c == CH_SPACE) begin
						if (spaces < 255)
							spaces++;
					end else if (indent_is_bad()) begin
						line_err = ERR_INDENT;
						scan = SCAN_SKIP;
					end else begin
						scan = SCAN_NORMAL;
						scan_normal(c);
					end
				end
				SCAN_NORMAL: scan_normal(c);
				SCAN_QUOTED: begin
					if (c == CH_DQUOTE && !esc) begin
						hold_byte(c);
						scan = SCAN_NORMAL;
					end else begin
						esc = (c == CH_BSLASH) ? !esc : 1'b0;
						hold_byte(c);
					end
				end
				default: ;
			endcase
		end else begin
			if (scan == SCAN_LEAD) begin
				if (indent_is_bad())
					line_err = ERR_INDENT;
			end else if (scan == SCAN_QUOTED) begin
				hold_byte(CH_SPACE);
				flush_token();
				if (line_err == ERR_NONE)
					line_err = ERR_QUOTE;
			end else if (scan == SCAN_NORMAL) begin
				flush_token();
			end
			r.is_outcome = 1'b1;
			r.ch = '0;
			r.tok_end = 1'b0;
			r.err = line_err;
			r.level = (line_err == ERR_INDENT) ? '0 : LEVEL_W'(spaces / INDENT_WIDTH_DEF);
			r.last = 1'b0;
			item_results.insert(item_results.size(), r);
			clear_line();
		end
		if (item_results.size() > 0)
			item_results[item_results.size() - 1].last = 1'b1;
		foreach (item_results[i])
			expected_results.insert(expected_results.size(), item_results[i]);
	endfunction

	function automatic string fmt_result(tok_result_t r);
		return $sformatf("kind=%0d char=%h end=%0d level=%0d err=%0d last=%0d",
		                 r.is_outcome, r.ch, r.tok_end, r.level, r.err, r.last);
	endfunction

	// Output side: random or long stalls, and a check of every accepted result.
	always @(posedge clk) begin
		if (stall_asked != stall_taken) begin
			stall_taken <= stall_asked;
			stall_left <= LONG_STALL;
			m_axis_tready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin : check_results
		tok_result_t want;
		tok_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.ch = m_axis_tdata[7:0];
			got.tok_end = m_axis_tdata[8];
			got.level = m_axis_tdata[14:9];
			got.err = m_axis_tdata[16:15];
			got.is_outcome = m_axis_tuser;
			got.last = m_axis_tlast;
			if (expected_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: %s", fmt_result(got));
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (want.is_outcome)
					outcomes_checked++;
				if (got.is_outcome !== want.is_outcome || got.ch !== want.ch ||
				    got.tok_end !== want.tok_end || got.level !== want.level ||
				    got.err !== want.err || got.last !== want.last) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: expected %s, got %s",
						         fmt_result(want), fmt_result(got));
				end
			end
		end
	end

	// Offer one request after a random gap and wait until it is taken.
	task automatic send_item(input logic kind, input logic [7:0] c);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tuser <= kind;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_item(kind, c);
		items_sent++;
	endtask

	// Send the buffered line bytes, then the end of line.
	task automatic send_line();
		foreach (line_buf[i])
			send_item(1'b0, line_buf[i]);
		send_item(1'b1, 8'($urandom_range(0, 255)));
		line_buf.delete();
		lines_sent++;
	endtask

	task automatic append_text(input string s);
		for (int i = 0; i < s.len(); i++)
			buf_byte(s[i]);
	endtask

	task automatic set_idling(input int tx, input int rx);
		tx_idle_pct = tx;
		rx_idle_pct <= rx;
	endtask

	task automatic test_quote_rewrite();
		append_text("\"x\" \"\\q\"");
		send_line();
	endtask

	task automatic test_bar_semicolon_comment();
		append_text("|a;|b#(");
		send_line();
		// Empty line, then the byte extremes as one token.
		send_line();
		buf_byte(8'h00);
		buf_byte(8'hFF);
		send_line();
	endtask

	task automatic test_line_errors();
		append_text("  x");
		send_line();
		append_text("abcdef(");
		send_line();
		append_text("\"a\\\"");
		send_line();
	endtask

	// Deepest legal indentation, and a bad space count found at the line end.
	task automatic test_indent_limits();
		repeat (252)
			buf_byte(CH_SPACE);
		append_text("x");
		send_line();
		append_text("   ");
		send_line();
	endtask

	// Hold the output off for a long stretch while short tokens keep coming.
	task automatic test_output_backpressure();
		stall_asked <= stall_asked + 1;
		append_text("a;b;c;d;e;f;g;h;i;j; longtoken \"x\";");
		send_line();
	endtask

	// Build a mostly well-formed line with random content and some noise.
	task automatic build_random_line();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 7)
			repeat (4 * $urandom_range(0, 3))
				buf_byte(CH_SPACE);
		else if (pick < 9)
			repeat ($urandom_range(1, 7))
				buf_byte(CH_SPACE);
		repeat ($urandom_range(0, 5)) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3:
					repeat ($urandom_range(1, 7))
						buf_byte(8'(8'h61 + $urandom_range(0, 25)));
				4: begin
					buf_byte(CH_DQUOTE);
					if ($urandom_range(0, 1))
						buf_byte(CH_BSLASH);
					buf_byte(8'($urandom_range(33, 126)));
					buf_byte(CH_DQUOTE);
				end
				5: begin
					buf_byte(CH_DQUOTE);
					repeat ($urandom_range(0, 6)) begin
						pick = $urandom_range(0, 5);
						if (pick == 0)
							buf_byte(CH_BSLASH);
						else if (pick == 1)
							buf_byte(CH_SPACE);
						else
							buf_byte(8'(8'h61 + $urandom_range(0, 25)));
					end
					buf_byte(CH_DQUOTE);
				end
				6: buf_byte(CH_SEMI);
				7: buf_byte(CH_BAR);
				8:
					repeat ($urandom_range(1, 3))
						buf_byte(8'($urandom_range(0, 255)));
				default: begin
					case ($urandom_range(0, 3))
						0: append_text("#c (x)");
						1: begin
							case ($urandom_range(0, 5))
								0: buf_byte(CH_LPAREN);
								1: buf_byte(CH_RPAREN);
								2: buf_byte(CH_LBRACE);
								3: buf_byte(CH_RBRACE);
								4: buf_byte(CH_LBRACK);
								default: buf_byte(CH_RBRACK);
							endcase
						end
						2: buf_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
						default: append_text("\"op");
					endcase
				end
			endcase
			if ($urandom_range(0, 3) != 0)
				buf_byte(CH_SPACE);
		end
	endtask

	task automatic test_random_lines(input int n_items);
		int start;
		start = items_sent;
		while (items_sent - start < n_items) begin
			build_random_line();
			send_line();
		end
	endtask

	initial begin
		clear_line();
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(17, 75);
		test_quote_rewrite();
		test_bar_semicolon_comment();
		test_line_errors();
		test_random_lines(30);

		set_idling(75, 17);
		test_output_backpressure();
		test_random_lines(35);

		set_idling(0, 0);
		test_indent_limits();
		test_random_lines(30);

		// Drain the outstanding results, then give the block time to go quiet.
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);

		$display("Sent %0d lines in %0d requests under three idling mixes and a long stall.",
		         lines_sent, items_sent);
		$display("Checked %0d results, %0d of them line outcomes; %0d failures.",
		         results_checked, outcomes_checked, fail_count);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(20 * 400000);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
